// ===== hw/rtl/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, widths, register indexes and saturation helper for the
// wheel speed PI controller with drive ramp.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int CNT_W       = 16;  // raw encoder count
  localparam int SUM_W       = 18;  // signed left + right
  localparam int ERR_W       = 19;  // speed error
  localparam int CHG_W       = 20;  // error change
  localparam int INTEG_W     = 12;  // clamped integral, tenths
  localparam int ACC_W       = 20;  // integral + error before clamp
  localparam int GAIN_W      = 16;
  localparam int TARGET_W    = 16;
  localparam int PROD_P_W    = ERR_W + GAIN_W + 1;
  localparam int PROD_I_W    = INTEG_W + GAIN_W + 1;
  localparam int DSUM_W      = PROD_P_W + 1;
  localparam int DRIVE_W     = 32;
  localparam int DIFF_W      = DRIVE_W + 1;
  localparam int SAT_IN_W    = 40;
  localparam int MAG_W       = 32;
  localparam int HALF_W      = MAG_W / 2;
  localparam int MAGIC_W     = 33;
  localparam int PP_W        = HALF_W + MAGIC_W;
  localparam int FULL_W      = PP_W + HALF_W;
  localparam int SMOOTH_W    = DIFF_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  typedef enum logic {
    OP_CONTROL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_TARGET = 2'd0,
    REG_GAIN_P       = 2'd1,
    REG_GAIN_I       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
    logic             left_dir_pin;
    logic             right_dir_pin;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] speed_sum;
    logic signed [ERR_W-1:0] speed_error;
    logic signed [CHG_W-1:0] error_change;
  } speed_info_t;

  // Per-stage handshake: load = the next register may take a new value,
  // commit = a valid item leaves this stage.
  typedef struct packed {
    logic load;
    logic commit;
  } stage_ctl_t;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic [SAT_IN_W-DRIVE_W:0] top_bits;
    top_bits = v[SAT_IN_W-1:DRIVE_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      return v[DRIVE_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/wsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsp_ctrl
// Signs the encoder counts, forms speed, error and error change, keeps the
// clamped integral and registers the two PI products.
// ----------------------------------------------------------------------------
module wsp_ctrl
  import wsp_pkg::*;
#(
  parameter int INTEGRAL_LIMIT = 2000
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stage_ctl_t                   ctl,
  input  in_item_t                     item,
  input  logic signed [TARGET_W-1:0]   speed_target,
  input  logic        [GAIN_W-1:0]     gain_p,
  input  logic        [GAIN_W-1:0]     gain_i,
  output op_t                          op_q,
  output logic signed [PROD_P_W-1:0]   prod_p,
  output logic signed [PROD_I_W-1:0]   prod_i,
  output speed_info_t                  info
);

  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(INTEGRAL_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(INTEGRAL_LIMIT);

  logic signed [INTEG_W-1:0]  integral;
  logic signed [SUM_W-1:0]    last_speed_sum;
  logic signed [ERR_W-1:0]    last_error;
  logic signed [CHG_W-1:0]    last_change;

  logic signed [CNT_W:0]      left_mag, right_mag, left_s, right_s;
  logic signed [SUM_W-1:0]    sum;
  logic signed [ERR_W-1:0]    err;
  logic signed [CHG_W-1:0]    change;
  logic signed [ACC_W-1:0]    acc_raw;
  logic signed [INTEG_W-1:0]  integral_next;
  logic signed [GAIN_W:0]     gain_p_s, gain_i_s;
  logic signed [PROD_P_W-1:0] prod_p_next;
  logic signed [PROD_I_W-1:0] prod_i_next;
  logic                       is_control;

  assign is_control = (item.op == OP_CONTROL);

  always_comb begin
    left_mag  = $signed({1'b0, item.left_count});
    right_mag = $signed({1'b0, item.right_count});
    left_s    = item.left_dir_pin  ? -left_mag  : left_mag;
    right_s   = item.right_dir_pin ? right_mag  : -right_mag;
    sum       = SUM_W'(left_s) + SUM_W'(right_s);
    err       = ERR_W'(sum) - ERR_W'(speed_target);
    change    = CHG_W'(err) - CHG_W'(last_error);
    acc_raw   = ACC_W'(integral) + ACC_W'(err);
    // clamp after adding the error, before it feeds the drive
    priority if (acc_raw >= LIM_POS) begin
      integral_next = INTEG_W'(LIM_POS);
    end else if (acc_raw <= LIM_NEG) begin
      integral_next = INTEG_W'(LIM_NEG);
    end else begin
      integral_next = INTEG_W'(acc_raw);
    end
    gain_p_s    = $signed({1'b0, gain_p});
    gain_i_s    = $signed({1'b0, gain_i});
    prod_p_next = PROD_P_W'(err) * PROD_P_W'(gain_p_s);
    prod_i_next = PROD_I_W'(integral_next) * PROD_I_W'(gain_i_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral       <= '0;
      last_speed_sum <= '0;
      last_error     <= '0;
      last_change    <= '0;
    end else if (ctl.commit && is_control) begin
      integral       <= integral_next;
      last_speed_sum <= sum;
      last_error     <= err;
      last_change    <= change;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q   <= item.op;
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      if (is_control) begin
        info <= '{speed_sum: sum, speed_error: err, error_change: change};
      end else begin
        // ticks repeat the figures of the last control update
        info <= '{speed_sum: last_speed_sum, speed_error: last_error,
                  error_change: last_change};
      end
    end
  end

  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    (integral <= INTEG_W'(LIM_POS)) && (integral >= INTEG_W'(LIM_NEG)))
    else $error("integral outside clamp range");

  a_tick_keeps_integral: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && !is_control) |=> $stable(integral) && $stable(last_error))
    else $error("tick item changed control state");

endmodule

// ===== hw/rtl/wsp_ramp.sv =====
// ----------------------------------------------------------------------------
// wsp_ramp
// Saturates the PI drive, divides the drive change by the ramp step count
// with a split reciprocal multiply, and steps the smoothed drive on ticks.
// ----------------------------------------------------------------------------
module wsp_ramp
  import wsp_pkg::*;
#(
  parameter int RAMP_STEPS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  stage_ctl_t                  ctl2,
  input  stage_ctl_t                  ctl3,
  input  stage_ctl_t                  ctl4,
  input  op_t                         op2,
  input  logic signed [PROD_P_W-1:0]  prod_p,
  input  logic signed [PROD_I_W-1:0]  prod_i,
  input  speed_info_t                 info2,
  output logic signed [DRIVE_W-1:0]   drive,
  output speed_info_t                 info_out
);

  // floor(d / N) = (d * ceil(2^(32+l) / N)) >> (32+l), exact for d < 2^32
  localparam int             RS_LOG  = $clog2(RAMP_STEPS);
  localparam int             SHIFT   = MAG_W + RS_LOG;
  localparam logic [63:0]    MAGIC64 = ((64'd1 << SHIFT) + 64'(RAMP_STEPS) - 64'd1)
                                       / 64'(RAMP_STEPS);
  localparam logic [MAGIC_W-1:0] MAGIC = MAGIC64[MAGIC_W-1:0];

  logic signed [DRIVE_W-1:0]  drive_new;
  logic signed [DIFF_W-1:0]   ramp_step;
  logic signed [DRIVE_W-1:0]  drive_smoothed;

  // stage 2 -> 3
  logic signed [DSUM_W-1:0]   total;
  logic signed [DRIVE_W-1:0]  drive_calc;
  logic signed [DIFF_W-1:0]   diff, diff_neg;
  logic        [MAG_W-1:0]    mag_next;

  op_t                        op3, op4;
  logic                       neg3, neg4;
  logic        [MAG_W-1:0]    mag3;
  speed_info_t                info3, info4;

  // stage 3 -> 4
  logic        [PP_W-1:0]     pp_hi_next, pp_lo_next, pp_hi4, pp_lo4;

  // stage 4 -> output
  logic        [FULL_W-1:0]   prod_full;
  logic        [MAG_W-1:0]    quot;
  logic signed [DIFF_W-1:0]   quot_s, step_next;
  logic signed [SMOOTH_W-1:0] smooth_sum;
  logic signed [DRIVE_W-1:0]  smooth_next;

  always_comb begin
    total      = DSUM_W'(prod_p) + DSUM_W'(prod_i);
    drive_calc = sat_drive(SAT_IN_W'(total));
    diff       = DIFF_W'(drive_calc) - DIFF_W'(drive_new);
    diff_neg   = -diff;
    mag_next   = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_new <= '0;
    end else if (ctl2.commit && op2 == OP_CONTROL) begin
      drive_new <= drive_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl2.load) begin
      op3   <= op2;
      neg3  <= diff[DIFF_W-1];
      mag3  <= mag_next;
      info3 <= info2;
    end
  end

  assign pp_hi_next = PP_W'(mag3[MAG_W-1:HALF_W]) * PP_W'(MAGIC);
  assign pp_lo_next = PP_W'(mag3[HALF_W-1:0]) * PP_W'(MAGIC);

  always_ff @(posedge clk) begin
    if (ctl3.load) begin
      op4    <= op3;
      neg4   <= neg3;
      pp_hi4 <= pp_hi_next;
      pp_lo4 <= pp_lo_next;
      info4  <= info3;
    end
  end

  always_comb begin
    prod_full   = {pp_hi4, {HALF_W{1'b0}}} + FULL_W'(pp_lo4);
    quot        = MAG_W'(prod_full >> SHIFT);
    quot_s      = $signed({1'b0, quot});
    // truncate toward zero: divide the magnitude, then restore the sign
    step_next   = neg4 ? -quot_s : quot_s;
    smooth_sum  = SMOOTH_W'(drive_smoothed) + SMOOTH_W'(ramp_step);
    smooth_next = sat_drive(SAT_IN_W'(smooth_sum));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step      <= '0;
      drive_smoothed <= '0;
    end else if (ctl4.commit) begin
      if (op4 == OP_CONTROL) begin
        ramp_step <= step_next;
      end else begin
        drive_smoothed <= smooth_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl4.load) begin
      drive    <= (op4 == OP_TICK) ? smooth_next : drive_smoothed;
      info_out <= info4;
    end
  end

  a_control_keeps_smoothed: assert property (@(posedge clk) disable iff (rst)
    (ctl4.commit && op4 == OP_CONTROL) |=> $stable(drive_smoothed))
    else $error("control item moved the smoothed drive");

  a_tick_keeps_step: assert property (@(posedge clk) disable iff (rst)
    (ctl4.commit && op4 == OP_TICK) |=> $stable(ramp_step))
    else $error("tick item changed the ramp step");

endmodule

// ===== hw/rtl/wheel_speed_pi_with_ramp.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_pi_with_ramp
// Wheel speed PI controller with clamped integral and a ramped output drive.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: tuser is the op (0 control update, 1 ramp tick),
// tdata carries both encoder counts and direction pins. A control update
// refreshes speed, error, integral and the PI drive; a tick adds one ramp step,
// the last PI drive change divided by RAMP_STEPS, to the smoothed drive. Each
// accepted item yields exactly one result on m_*: smoothed drive plus the
// speed figures of the last control update.
// From the accepting edge an item passes through the input register, the PI
// product stage, the drive difference stage, the split reciprocal multiply
// and the output register to m_tvalid. One item is accepted per cycle while
// s_tready is high; each stage moves on as soon as the stage after it is
// free, so a stalled m_tready fills the stages one by one and s_tready drops
// only when all five hold an item.
// Configuration writes (target, gains) take effect on the next control
// update. Reset clears all controller state and the gains and target to 0.
// ----------------------------------------------------------------------------
module wheel_speed_pi_with_ramp
  import wsp_pkg::*;
#(
  parameter int RAMP_STEPS     = 20,
  parameter int INTEGRAL_LIMIT = 2000
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [15:0] left_count, [31:16] right_count, [32] left_dir_pin,
  // [33] right_dir_pin, [39:34] zero
  input  logic [IN_TDATA_W-1:0]   s_tdata,
  // [0] op
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [31:0] drive, [49:32] speed_sum, [68:50] speed_error,
  // [88:69] error_change, [95:89] zero
  output logic [OUT_TDATA_W-1:0]  m_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic signed [TARGET_W-1:0] speed_target;
  logic        [GAIN_W-1:0]   gain_p;
  logic        [GAIN_W-1:0]   gain_i;

  logic        v1, v2, v3, v4;
  logic        free1, free2, free3, free4, free5;
  stage_ctl_t  ctl1, ctl2, ctl3, ctl4;
  in_item_t    item1;

  op_t                        op2;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  speed_info_t                info2, info_out;
  logic signed [DRIVE_W-1:0]  drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_target <= '0;
      gain_p       <= '0;
      gain_i       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPEED_TARGET: speed_target <= $signed(cfg_data[TARGET_W-1:0]);
        REG_GAIN_P:       gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       gain_i       <= cfg_data[GAIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // a stage frees up when it is empty or its item moves on this cycle
  always_comb begin
    free5 = !m_tvalid || m_tready;
    free4 = !v4 || free5;
    free3 = !v3 || free4;
    free2 = !v2 || free3;
    free1 = !v1 || free2;
    ctl1  = '{load: free2, commit: v1 && free2};
    ctl2  = '{load: free3, commit: v2 && free3};
    ctl3  = '{load: free4, commit: v3 && free4};
    ctl4  = '{load: free5, commit: v4 && free5};
  end

  assign s_tready = free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (free1) v1       <= s_tvalid;
      if (free2) v2       <= v1;
      if (free3) v3       <= v2;
      if (free4) v4       <= v3;
      if (free5) m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      item1 <= '{op:            op_t'(s_tuser),
                 left_count:    s_tdata[15:0],
                 right_count:   s_tdata[31:16],
                 left_dir_pin:  s_tdata[32],
                 right_dir_pin: s_tdata[33]};
    end
  end

  wsp_ctrl #(
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl1),
    .item         (item1),
    .speed_target (speed_target),
    .gain_p       (gain_p),
    .gain_i       (gain_i),
    .op_q         (op2),
    .prod_p       (prod_p),
    .prod_i       (prod_i),
    .info         (info2)
  );

  wsp_ramp #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_ramp (
    .clk      (clk),
    .rst      (rst),
    .ctl2     (ctl2),
    .ctl3     (ctl3),
    .ctl4     (ctl4),
    .op2      (op2),
    .prod_p   (prod_p),
    .prod_i   (prod_i),
    .info2    (info2),
    .drive    (drive),
    .info_out (info_out)
  );

  assign m_tdata = {7'd0, info_out.error_change, info_out.speed_error,
                    info_out.speed_sum, drive};

  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && m_tvalid && !m_tready))
    else $error("input stalled while a stage is free");

endmodule
